// ----- hw/rtl/rle_pkg.sv -----
// Shared types and constants for the Raft leader election block.
// No dependencies; imported by raft_leader_election.
`default_nettype none

package rle_pkg;

    // Cluster size limit; majority is computed against the clamped peer count
    localparam int MAX_PEERS = 8;

    localparam int TERM_W   = 32;
    localparam int ID_W     = 3;
    localparam int PEERS_W  = 4;
    localparam int TICK_W   = 16;
    localparam int CNT_W    = 4;
    localparam int MAJ_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Packed widths of the stream payloads, padded to whole bytes
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 104;

    localparam logic [TICK_W-1:0]  LFSR_SEED       = 16'd44257;
    localparam logic [TICK_W-1:0]  LFSR_TAPS       = 16'hB400;
    localparam logic [TICK_W-1:0]  TIMEOUT_MIN_RST = 16'd150;
    localparam logic [TICK_W-1:0]  TIMEOUT_MAX_RST = 16'd300;
    localparam logic [PEERS_W-1:0] PEER_COUNT_RST  = 4'd5;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_VOTE_REQ   = 2'd1,
        MODE_VOTE_REPLY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EXPIRED = 2'd1,
        STATUS_VOTED   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_REPLY     = 1'b0,
        KIND_BROADCAST = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID     = 3'd0,
        CFG_PEER_COUNT  = 3'd1,
        CFG_TIMEOUT_MIN = 3'd2,
        CFG_TIMEOUT_MAX = 3'd3,
        CFG_LAST_INDEX  = 3'd4,
        CFG_LAST_TERM   = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/raft_leader_election.sv -----
// Raft leader election engine for one node: term, role, vote and election timer.
// Depends on rle_pkg for types and constants.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = mode, s_tdata = message fields
// m_*       out  m_tvalid/m_tready  m_tuser = kind, m_tdata = result fields
// cfg_*     in   cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// One request is taken per cycle unless a deadline is being drawn; its result lands
// in the output register on the same edge, and a new request is taken while that
// result waits if the downstream side takes it in that cycle. Drawing a new election
// deadline (election start or granted vote) with timeout_max not below timeout_min
// runs a bit-serial remainder unit; s_tready and cfg_ready stay low while it runs.
// With timeout_max below timeout_min the deadline loads at once and the request
// does not hold off the requests behind it.
// Reset is asynchronous and active low; it loads the default configuration,
// the LFSR seed and a deadline of the default minimum timeout.
module raft_leader_election
    import rle_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] msg_term, [34:32] candidate_id, [66:35] msg_last_log_index,
    // [98:67] msg_last_log_term, [99] granted_in, [103:100] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] out_term, [34:32] out_candidate, [66:35] out_last_index,
    // [98:67] out_last_term, [99] reply_granted, [101:100] reply_status,
    // [103:102] role_now
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // [0] kind
    output logic                       m_tuser,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [ID_W-1:0]    node_id_reg;
    logic [PEERS_W-1:0] peer_count_reg;
    logic [TICK_W-1:0]  timeout_min_reg;
    logic [TICK_W-1:0]  timeout_max_reg;
    logic [TERM_W-1:0]  local_index_reg;
    logic [TERM_W-1:0]  local_term_reg;

    // Node state
    logic [TERM_W-1:0]  term_reg, term_next;
    role_t              role_reg, role_next;
    logic               has_voted_reg, has_voted_next;
    logic [ID_W-1:0]    voted_for_reg, voted_for_next;
    logic [CNT_W-1:0]   vote_count_reg, vote_count_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]  deadline_reg;
    logic [TICK_W-1:0]  lfsr_reg;

    // Remainder unit: lfsr mod span, one dividend bit per cycle
    logic               div_busy_reg;
    logic [3:0]         div_cnt_reg;
    logic [TICK_W-1:0]  div_shift_reg;
    logic [TICK_W:0]    div_rem_reg;
    logic [TICK_W:0]    div_rem_next;
    logic [TICK_W+1:0]  div_rem_shifted;
    logic [TICK_W:0]    span;

    // Output register
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Decoded request fields
    logic [TERM_W-1:0]  in_term;
    logic [ID_W-1:0]    in_cand;
    logic [TERM_W-1:0]  in_last_index;
    logic [TERM_W-1:0]  in_last_term;
    logic               in_granted;

    logic               accept;
    logic               emit;
    logic               draw;
    kind_t              res_kind;
    logic               res_granted;
    status_t            res_status;
    logic [OUT_DATA_W-1:0] res_data;

    logic [TICK_W-1:0]  lfsr_step;
    logic [MAJ_W-1:0]   peers_eff;
    logic [MAJ_W-1:0]   majority;
    logic [TICK_W-1:0]  elapsed_inc;
    logic [CNT_W-1:0]   count_inc;
    logic               adopt;
    logic               voted_eff;
    logic [ID_W-1:0]    voted_for_eff;
    logic               up_to_date;

    assign in_term       = s_tdata[31:0];
    assign in_cand       = s_tdata[34:32];
    assign in_last_index = s_tdata[66:35];
    assign in_last_term  = s_tdata[98:67];
    assign in_granted    = s_tdata[99];

    // Hold off new requests and config while a deadline is being computed
    assign s_tready  = !div_busy_reg && (!out_valid_reg || m_tready);
    assign cfg_ready = !div_busy_reg;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    // Galois LFSR advance, taken on every deadline draw
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    assign span = {1'b0, timeout_max_reg} - {1'b0, timeout_min_reg} + 17'd1;

    // Majority of the clamped cluster size
    always_comb
    begin
        peers_eff = {{(MAJ_W-PEERS_W){1'b0}}, peer_count_reg};
        if (peer_count_reg == '0)
        begin
            peers_eff = MAJ_W'(1);
        end
        else if (peers_eff > MAJ_W'(MAX_PEERS))
        begin
            peers_eff = MAJ_W'(MAX_PEERS);
        end
        majority = (peers_eff >> 1) + MAJ_W'(1);
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + TICK_W'(1) : elapsed_reg;
    assign count_inc   = (vote_count_reg != '1) ? vote_count_reg + CNT_W'(1) : vote_count_reg;

    // Vote request checks: adopt a higher term, then test log freshness
    assign adopt         = in_term > term_reg;
    assign voted_eff     = adopt ? 1'b0 : has_voted_reg;
    assign voted_for_eff = adopt ? '0 : voted_for_reg;
    assign up_to_date    = (in_last_term > local_term_reg) ||
                           ((in_last_term == local_term_reg) &&
                            (in_last_index >= local_index_reg));

    // Per-request state update and result
    always_comb
    begin
        term_next       = term_reg;
        role_next       = role_reg;
        has_voted_next  = has_voted_reg;
        voted_for_next  = voted_for_reg;
        vote_count_next = vote_count_reg;
        elapsed_next    = elapsed_reg;
        emit            = 1'b0;
        draw            = 1'b0;
        res_kind        = KIND_REPLY;
        res_granted     = 1'b0;
        res_status      = STATUS_OK;

        case (s_tuser)
            MODE_TICK:
            begin
                if (role_reg == ROLE_LEADER)
                begin
                    // Leader keeps its timer parked
                    elapsed_next = '0;
                end
                else if (elapsed_inc < deadline_reg)
                begin
                    elapsed_next = elapsed_inc;
                end
                else
                begin
                    // Timer expired: start an election and broadcast a request
                    term_next       = (term_reg != '1) ? term_reg + TERM_W'(1) : term_reg;
                    has_voted_next  = 1'b1;
                    voted_for_next  = node_id_reg;
                    vote_count_next = CNT_W'(1);
                    elapsed_next    = '0;
                    draw            = 1'b1;
                    role_next       = (MAJ_W'(1) >= majority) ? ROLE_LEADER : ROLE_CANDIDATE;
                    emit            = 1'b1;
                    res_kind        = KIND_BROADCAST;
                end
            end
            MODE_VOTE_REQ:
            begin
                emit = 1'b1;
                if (in_term < term_reg)
                begin
                    res_status = STATUS_EXPIRED;
                end
                else
                begin
                    if (adopt)
                    begin
                        term_next       = in_term;
                        role_next       = ROLE_FOLLOWER;
                        has_voted_next  = 1'b0;
                        voted_for_next  = '0;
                        vote_count_next = '0;
                    end
                    if (!up_to_date)
                    begin
                        res_status = STATUS_EXPIRED;
                    end
                    else if (voted_eff && (voted_for_eff != in_cand))
                    begin
                        res_status = STATUS_VOTED;
                    end
                    else
                    begin
                        has_voted_next = 1'b1;
                        voted_for_next = in_cand;
                        res_granted    = 1'b1;
                        elapsed_next   = '0;
                        draw           = 1'b1;
                    end
                end
            end
            MODE_VOTE_REPLY:
            begin
                if (adopt)
                begin
                    term_next       = in_term;
                    role_next       = ROLE_FOLLOWER;
                    has_voted_next  = 1'b0;
                    voted_for_next  = '0;
                    vote_count_next = '0;
                end
                else if ((role_reg == ROLE_CANDIDATE) && (in_term == term_reg) && in_granted)
                begin
                    vote_count_next = count_inc;
                    if ({{(MAJ_W-CNT_W){1'b0}}, count_inc} >= majority)
                    begin
                        role_next = ROLE_LEADER;
                    end
                end
            end
            default:
            begin
                // Unused mode: drop silently
            end
        endcase
    end

    // Pack the result; broadcast carries own identity and log position
    always_comb
    begin
        res_data         = '0;
        res_data[31:0]   = term_next;
        res_data[101:100] = 2'(res_status);
        res_data[103:102] = 2'(role_next);
        if (res_kind == KIND_BROADCAST)
        begin
            res_data[34:32] = node_id_reg;
            res_data[66:35] = local_index_reg;
            res_data[98:67] = local_term_reg;
        end
        else
        begin
            res_data[99] = res_granted;
        end
    end

    // Restoring remainder step
    always_comb
    begin
        div_rem_shifted = {div_rem_reg, div_shift_reg[TICK_W-1]};
        if (div_rem_shifted >= {1'b0, span})
        begin
            div_rem_next = (TICK_W+1)'(div_rem_shifted - {1'b0, span});
        end
        else
        begin
            div_rem_next = div_rem_shifted[TICK_W:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= '0;
            peer_count_reg  <= PEER_COUNT_RST;
            timeout_min_reg <= TIMEOUT_MIN_RST;
            timeout_max_reg <= TIMEOUT_MAX_RST;
            local_index_reg <= '0;
            local_term_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_ID:     node_id_reg     <= cfg_data[ID_W-1:0];
                CFG_PEER_COUNT:  peer_count_reg  <= cfg_data[PEERS_W-1:0];
                CFG_TIMEOUT_MIN: timeout_min_reg <= cfg_data[TICK_W-1:0];
                CFG_TIMEOUT_MAX: timeout_max_reg <= cfg_data[TICK_W-1:0];
                CFG_LAST_INDEX:  local_index_reg <= cfg_data[TERM_W-1:0];
                CFG_LAST_TERM:   local_term_reg  <= cfg_data[TERM_W-1:0];
                default:
                begin
                    // Unmapped index: ignore the write
                end
            endcase
        end
    end

    // Node state, deadline draw and remainder unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg       <= '0;
            role_reg       <= ROLE_FOLLOWER;
            has_voted_reg  <= 1'b0;
            voted_for_reg  <= '0;
            vote_count_reg <= '0;
            elapsed_reg    <= '0;
            deadline_reg   <= TIMEOUT_MIN_RST;
            lfsr_reg       <= LFSR_SEED;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            div_shift_reg  <= '0;
            div_rem_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                term_reg       <= term_next;
                role_reg       <= role_next;
                has_voted_reg  <= has_voted_next;
                voted_for_reg  <= voted_for_next;
                vote_count_reg <= vote_count_next;
                elapsed_reg    <= elapsed_next;
                if (draw)
                begin
                    lfsr_reg <= lfsr_step;
                    if (timeout_max_reg < timeout_min_reg)
                    begin
                        deadline_reg <= timeout_min_reg;
                    end
                    else
                    begin
                        div_busy_reg  <= 1'b1;
                        div_cnt_reg   <= '0;
                        div_shift_reg <= lfsr_step;
                        div_rem_reg   <= '0;
                    end
                end
            end
            else if (div_busy_reg)
            begin
                div_rem_reg   <= div_rem_next;
                div_shift_reg <= div_shift_reg << 1;
                div_cnt_reg   <= div_cnt_reg + 4'd1;
                if (div_cnt_reg == '1)
                begin
                    // Last bit: remainder is final, release the block
                    div_busy_reg <= 1'b0;
                    deadline_reg <= timeout_min_reg + div_rem_next[TICK_W-1:0];
                end
            end
        end
    end

    // Output register: load on a producing request, clear when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_REPLY;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= res_kind;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for raft_leader_election: a scoreboard class predicts each reply and
// broadcast from the accepted events, plain tasks drive the event and config channels.
// Depends on rle_pkg and the raft_leader_election RTL.

module testbench;
    import rle_pkg::*;

    // Mode code that the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles to let pass after the last result before touching the config port
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold-off
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTED = 50;

    // One incoming event as carried on the slave stream
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] term;
        logic [2:0]  cand;
        logic [31:0] lidx;
        logic [31:0] lterm;
        logic        granted;
    } event_t;

    // One outgoing message as carried on the master stream
    typedef struct {
        kind_t       kind;
        logic [31:0] term;
        logic [2:0]  cand;
        logic [31:0] lidx;
        logic [31:0] lterm;
        logic        granted;
        status_t     status;
        role_t       role;
    } message_t;

    class vote_scoreboard;
        // configuration copy
        logic [2:0]  node_id;
        logic [3:0]  peer_count;
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic [31:0] last_index;
        logic [31:0] last_term;
        // node state copy
        logic [31:0] term;
        role_t       role;
        logic        voted;
        logic [2:0]  voted_for;
        logic [3:0]  votes;
        logic [15:0] elapsed;
        logic [15:0] deadline;
        logic [15:0] lfsr;
        // messages the block still owes us, oldest first
        message_t    pending_msgs[$];
        int          errors;

        function new();
            node_id    = '0;
            peer_count = PEER_COUNT_RST;
            tmin       = TIMEOUT_MIN_RST;
            tmax       = TIMEOUT_MAX_RST;
            last_index = '0;
            last_term  = '0;
            term       = '0;
            role       = ROLE_FOLLOWER;
            voted      = 1'b0;
            voted_for  = '0;
            votes      = '0;
            elapsed    = '0;
            deadline   = TIMEOUT_MIN_RST;
            lfsr       = LFSR_SEED;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_NODE_ID:     node_id    = value[2:0];
                CFG_PEER_COUNT:  peer_count = value[3:0];
                CFG_TIMEOUT_MIN: tmin       = value[15:0];
                CFG_TIMEOUT_MAX: tmax       = value[15:0];
                CFG_LAST_INDEX:  last_index = value;
                CFG_LAST_TERM:   last_term  = value;
                default: ;
            endcase
        endfunction

        function int unsigned majority();
            int unsigned n;
            n = peer_count;
            if (n < 1) n = 1;
            if (n > MAX_PEERS) n = MAX_PEERS;
            return n / 2 + 1;
        endfunction

        // Step the Galois LFSR once and draw the next election deadline from it
        function void next_deadline();
            logic        lsb;
            int unsigned span;
            lsb  = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr = lfsr ^ LFSR_TAPS;
            if (tmax < tmin)
            begin
                deadline = tmin;
            end
            else
            begin
                span     = {16'd0, tmax} - {16'd0, tmin} + 1;
                deadline = 16'({16'd0, tmin} + {16'd0, lfsr} % span);
            end
        endfunction

        function void step_down(logic [31:0] t);
            term      = t;
            role      = ROLE_FOLLOWER;
            voted     = 1'b0;
            voted_for = '0;
            votes     = '0;
        endfunction

        // Apply one accepted event and queue the message it should produce
        function void apply_event(event_t ev);
            message_t msg;
            logic     fresh;
            msg = '{KIND_REPLY, '0, '0, '0, '0, 1'b0, STATUS_OK, ROLE_FOLLOWER};
            case (ev.mode)
                MODE_TICK:
                begin
                    if (role == ROLE_LEADER)
                    begin
                        elapsed = '0;
                    end
                    else
                    begin
                        if (elapsed != 16'hFFFF) elapsed = elapsed + 1'b1;
                        if (elapsed >= deadline)
                        begin
                            if (term != 32'hFFFF_FFFF) term = term + 1;
                            role      = ROLE_CANDIDATE;
                            voted     = 1'b1;
                            voted_for = node_id;
                            votes     = 4'd1;
                            elapsed   = '0;
                            next_deadline();
                            if (votes >= majority()) role = ROLE_LEADER;
                            msg.kind  = KIND_BROADCAST;
                            msg.term  = term;
                            msg.cand  = node_id;
                            msg.lidx  = last_index;
                            msg.lterm = last_term;
                            msg.role  = role;
                            pending_msgs.insert(pending_msgs.size(), msg);
                        end
                    end
                end
                MODE_VOTE_REQ:
                begin
                    if (ev.term < term)
                    begin
                        msg.status = STATUS_EXPIRED;
                    end
                    else
                    begin
                        if (ev.term > term) step_down(ev.term);
                        fresh = (ev.lterm > last_term) ||
                                (ev.lterm == last_term && ev.lidx >= last_index);
                        if (!fresh)
                        begin
                            msg.status = STATUS_EXPIRED;
                        end
                        else if (voted && voted_for != ev.cand)
                        begin
                            msg.status = STATUS_VOTED;
                        end
                        else
                        begin
                            voted       = 1'b1;
                            voted_for   = ev.cand;
                            msg.granted = 1'b1;
                            elapsed     = '0;
                            next_deadline();
                        end
                    end
                    msg.term = term;
                    msg.role = role;
                    pending_msgs.insert(pending_msgs.size(), msg);
                end
                MODE_VOTE_REPLY:
                begin
                    if (ev.term > term)
                    begin
                        step_down(ev.term);
                    end
                    else if (role == ROLE_CANDIDATE && ev.term == term && ev.granted)
                    begin
                        if (votes != 4'd15) votes = votes + 1'b1;
                        if (votes >= majority()) role = ROLE_LEADER;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // Compare one delivered message against the oldest one still owed
        task check_outgoing(logic kind_bit, logic [OUT_DATA_W-1:0] data);
            message_t want;
            if (pending_msgs.size() == 0)
            begin
                report($sformatf("unexpected message kind %0d term 0x%0h", kind_bit,
                                 data[31:0]));
                return;
            end
            want = pending_msgs.pop_front();
            check_field("kind",           32'(kind_bit),      32'(want.kind));
            check_field("out_term",       data[31:0],         want.term);
            check_field("out_candidate",  32'(data[34:32]),   32'(want.cand));
            check_field("out_last_index", data[66:35],        want.lidx);
            check_field("out_last_term",  data[98:67],        want.lterm);
            check_field("reply_granted",  32'(data[99]),      32'(want.granted));
            check_field("reply_status",   32'(data[101:100]), 32'(want.status));
            check_field("role_now",       32'(data[103:102]), 32'(want.role));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [31:0] msg_term, [34:32] candidate_id, [66:35] msg_last_log_index,
    // [98:67] msg_last_log_term, [99] granted_in, [103:100] zero
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] mode
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [31:0] out_term, [34:32] out_candidate, [66:35] out_last_index,
    // [98:67] out_last_term, [99] reply_granted, [101:100] reply_status, [103:102] role_now
    logic [OUT_DATA_W-1:0] m_tdata;
    // [0] kind
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vote_scoreboard sb;

    // Idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for a long hold-off
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycles         = 0;

    raft_leader_election dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every message taken from the master side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_outgoing(m_tuser, m_tdata);
    end

    function automatic event_t mk(logic [1:0] mode, logic [31:0] term, logic [2:0] cand,
                                  logic [31:0] lidx, logic [31:0] lterm, logic granted);
        event_t ev;
        ev.mode    = mode;
        ev.term    = term;
        ev.cand    = cand;
        ev.lidx    = lidx;
        ev.lterm   = lterm;
        ev.granted = granted;
        return ev;
    endfunction

    // Draw a random event around the node's current term and log position; most are
    // well formed so elections and majorities happen, the rest is raw noise
    function automatic event_t random_event();
        event_t ev;
        int     pick;
        pick       = $urandom_range(99);
        ev.term    = sb.term + $urandom_range(2) - 1;
        ev.cand    = 3'($urandom_range(7));
        ev.lidx    = sb.last_index + $urandom_range(2) - 1;
        ev.lterm   = sb.last_term + $urandom_range(2) - 1;
        ev.granted = ($urandom_range(3) != 0);
        if (pick < 45)
        begin
            ev.mode = MODE_TICK;
        end
        else if (pick < 70)
        begin
            ev.mode = MODE_VOTE_REQ;
        end
        else if (pick < 88)
        begin
            ev.mode = MODE_VOTE_REPLY;
            if ($urandom_range(4) != 0) ev.term = sb.term;
        end
        else if (pick < 97)
        begin
            ev.mode    = 2'($urandom_range(2));
            ev.term    = $urandom;
            ev.lidx    = $urandom;
            ev.lterm   = $urandom;
            ev.granted = 1'($urandom_range(1));
        end
        else
        begin
            ev.mode = MODE_UNUSED;
        end
        return ev;
    endfunction

    // Offer one request, idle first at random; valid stays high after acceptance
    task automatic send(event_t ev);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {4'd0, ev.granted, ev.lterm, ev.lidx, ev.cand, ev.term};
        do @(posedge clk); while (!s_tready);
        sb.apply_event(ev);
    endtask

    // Drop valid, wait until every owed message is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_msgs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    // Write all registers; call only while the block is idle
    task automatic configure(logic [2:0] node, logic [3:0] peers, logic [15:0] tmin,
                             logic [15:0] tmax, logic [31:0] lidx, logic [31:0] lterm);
        write_reg(CFG_NODE_ID,     32'(node));
        write_reg(CFG_PEER_COUNT,  32'(peers));
        write_reg(CFG_TIMEOUT_MIN, 32'(tmin));
        write_reg(CFG_TIMEOUT_MAX, 32'(tmax));
        write_reg(CFG_LAST_INDEX,  lidx);
        write_reg(CFG_LAST_TERM,   lterm);
        cfg_valid <= 1'b0;
    endtask

    // Tick until the node leaves the follower role
    task automatic tick_to_election();
        do send(mk(MODE_TICK, $urandom, 3'd0, '0, '0, 1'b0));
        while (sb.role == ROLE_FOLLOWER);
    endtask

    // One phase of random traffic under one configuration and idling mix
    task automatic run_phase(logic [2:0] node, logic [3:0] peers, logic [15:0] tmin,
                             logic [15:0] tmax, logic [31:0] lidx, logic [31:0] lterm,
                             int idle_pct, int stall_pct, int count);
        event_t ev;
        int     n;
        drain();
        configure(node, peers, tmin, tmax, lidx, lterm);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        n = 0;
        while (n < count)
        begin
            // hold off the receiver while we keep pushing, so the block backs up
            if (n == count / 3) hold_requests++;
            // pause the sender until everything owed has come out
            if (n == 2 * count / 3) drain();
            ev = random_event();
            send(ev);
            if (ev.mode != MODE_UNUSED) n++;
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: node 3 of a three-node cluster with a short timer
        configure(3'd3, 4'd3, 16'd2, 16'd5, 32'd100, 32'd5);
        // grant on a newer term, refuse a lower term, refuse a second candidate
        send(mk(MODE_VOTE_REQ, 32'd1, 3'd2, 32'd100, 32'd5, 1'b1));
        send(mk(MODE_VOTE_REQ, 32'd0, 3'd2, 32'd100, 32'd5, 1'b0));
        send(mk(MODE_VOTE_REQ, 32'd1, 3'd4, 32'd200, 32'd6, 1'b0));
        // same candidate asks again: granted once more
        send(mk(MODE_VOTE_REQ, 32'd1, 3'd2, 32'd100, 32'd5, 1'b0));
        // newer term but stale log: older log term, then equal term with lower index
        send(mk(MODE_VOTE_REQ, 32'd2, 3'd1, 32'd500, 32'd4, 1'b0));
        send(mk(MODE_VOTE_REQ, 32'd2, 3'd1, 32'd99, 32'd5, 1'b0));
        // newer log term wins despite index zero
        send(mk(MODE_VOTE_REQ, 32'd2, 3'd1, 32'd0, 32'd6, 1'b1));
        // run the timer out and stand for election
        tick_to_election();
        // non-granting reply, stale granting reply, then the majority vote
        send(mk(MODE_VOTE_REPLY, sb.term, 3'd0, '0, '0, 1'b0));
        send(mk(MODE_VOTE_REPLY, sb.term - 1, 3'd0, '0, '0, 1'b1));
        send(mk(MODE_VOTE_REPLY, sb.term, 3'd0, '0, '0, 1'b1));
        // leader ticks give nothing; a request in its own term finds the vote taken
        send(mk(MODE_TICK, '0, 3'd0, '0, '0, 1'b0));
        send(mk(MODE_VOTE_REQ, sb.term, 3'd1, 32'd100, 32'd5, 1'b0));
        // unused mode, all data bits set
        send(mk(MODE_UNUSED, '1, 3'd7, '1, '1, 1'b1));
        // higher-term reply steps down
        send(mk(MODE_VOTE_REPLY, sb.term + 1, 3'd0, '0, '0, 1'b0));
        // largest term and log from candidate 7, then an election at the saturated term
        send(mk(MODE_VOTE_REQ, '1, 3'd7, '1, '1, 1'b1));
        tick_to_election();
        send(mk(MODE_VOTE_REQ, '0, 3'd0, '0, '0, 1'b0));

        // Random phases with changing settings and idling mixes
        run_phase(3'd5, 4'd3,  16'd2, 16'd6, 32'd1000, 32'd7, 0, 0, 400);
        run_phase(3'd7, 4'd8,  16'd1, 16'd1, '1, '1, 53, 0, 300);
        // single-node cluster (peer count zero) and max below min
        run_phase(3'd0, 4'd0,  16'd4, 16'd2, '0, '0, 0, 53, 300);
        // peer count above the limit
        run_phase(3'd2, 4'd15, 16'd1, 16'd12, 32'h8000_0001, 32'h7FFF_FFFE, 36, 36, 300);
        run_phase(3'd6, 4'd1,  16'hFFFF, 16'hFFFF, 32'd5, 32'd0, 0, 0, 150);

        run_phase(3'd1, 4'd4,  16'd2, 16'd9, 32'd77, 32'd3, 53, 0, 150);
        drain();

        if (sb.errors == 0 && sb.pending_msgs.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rle_pkg.sv
hw/rtl/raft_leader_election.sv
bench/testbench.sv
